FILE: src/ccs_pkg.sv
// Shared types, character codes and the per-byte comment decision.
package ccs_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic [7:0] prev;
    logic       in_str;
    logic       in_lc;
    logic       in_bc;
  } ccs_flags_t;

  localparam ccs_flags_t FLAGS_RST = '{prev: CH_NUL, in_str: 1'b0, in_lc: 1'b0, in_bc: 1'b0};

  typedef struct packed {
    ccs_flags_t flags;
    logic       keep;
  } ccs_dec_t;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       kept;
    logic       fin;
  } ccs_res_t;

  // Up to two results written into the queue in one cycle, packed from e0
  typedef struct packed {
    logic [1:0] cnt;
    ccs_res_t   e0;
    ccs_res_t   e1;
  } ccs_push_t;

  typedef struct packed {
    logic     nempty;
    ccs_res_t res;
  } ccs_qhead_t;

  function automatic ccs_dec_t ccs_decide(ccs_flags_t f, logic [7:0] b,
                                          logic nxt_slash, logic nxt_star);
    ccs_dec_t d;
    logic     closing;
    logic     outside;
    d       = '{flags: f, keep: 1'b0};
    closing = 1'b0;
    outside = !f.in_lc && !f.in_bc;
    if (b == CH_QUOTE) begin
      if (outside) d.flags.in_str = !f.in_str;
    end else if (b == CH_SLASH && nxt_slash && !f.in_bc) begin
      if (!f.in_str) d.flags.in_lc = 1'b1;
    end else if (b inside {CH_LF, CH_CR}) begin
      d.flags.in_lc = 1'b0;
    end else if (b == CH_SLASH && nxt_star && !f.in_lc) begin
      if (!f.in_str) d.flags.in_bc = 1'b1;
    end else if (!f.in_str && b == CH_SLASH && f.prev == CH_STAR) begin
      d.flags.in_bc = 1'b0;
      closing       = 1'b1;
    end
    d.flags.prev = closing ? CH_NUL : b;
    d.keep       = !closing && !d.flags.in_lc && !d.flags.in_bc;
    return d;
  endfunction

endpackage

FILE: src/ccs_in_if.sv
// Request channel carrying source bytes.
interface ccs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: src/ccs_out_if.sv
// Result channel carrying kept bytes and end-of-file marks.
interface ccs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_end;

  modport source (output valid, output out_byte, output out_valid, output out_end,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_end,
                  output ready);
endinterface

FILE: src/ccs_front.sv
// Front end: one-byte lookahead, comment/string flags, results into the queue.
module ccs_front (
  input  logic               clk,
  input  logic               rst_n,
  ccs_in_if.sink             in_ch,
  input  logic               q_room,
  output ccs_pkg::ccs_push_t push
);

  logic [7:0]          held_r;
  logic                present_r, present_nxt;
  ccs_pkg::ccs_flags_t flags_r, flags_nxt;

  ccs_pkg::ccs_dec_t   d_held, d_last;
  ccs_pkg::ccs_flags_t f_mid;
  ccs_pkg::ccs_res_t   e_held, e_last;
  logic                acc, k_held;

  assign in_ch.ready = q_room;
  assign acc         = in_ch.valid && q_room;

  always_comb begin
    d_held = ccs_pkg::ccs_decide(flags_r, held_r,
                                 in_ch.in_byte == ccs_pkg::CH_SLASH,
                                 in_ch.in_byte == ccs_pkg::CH_STAR);
    f_mid  = present_r ? d_held.flags : flags_r;
    // final byte is decided with nothing ahead of it
    d_last = ccs_pkg::ccs_decide(f_mid, in_ch.in_byte, 1'b0, 1'b0);
    k_held = present_r && d_held.keep;

    e_held = '{data: held_r, kept: 1'b1, fin: 1'b0};
    e_last = '{data: d_last.keep ? in_ch.in_byte : ccs_pkg::CH_NUL,
               kept: d_last.keep, fin: 1'b1};

    push.cnt = acc ? ({1'b0, k_held} + {1'b0, in_ch.in_last}) : 2'd0;
    push.e0  = k_held ? e_held : e_last;
    push.e1  = e_last;

    flags_nxt   = flags_r;
    present_nxt = present_r;
    if (acc) begin
      if (in_ch.in_last) begin
        flags_nxt   = ccs_pkg::FLAGS_RST;
        present_nxt = 1'b0;
      end else begin
        flags_nxt   = f_mid;
        present_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r   <= ccs_pkg::FLAGS_RST;
      present_r <= 1'b0;
    end else begin
      flags_r   <= flags_nxt;
      present_r <= present_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !in_ch.in_last) held_r <= in_ch.in_byte;
  end

endmodule

FILE: src/ccs_queue.sv
// Small register queue between front and back; takes up to two results a cycle.
module ccs_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ccs_pkg::ccs_push_t  push,
  input  logic                pop,
  output logic                room,
  output ccs_pkg::ccs_qhead_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ccs_pkg::ccs_res_t mem_r [DEPTH];
  logic [AW-1:0]     wr_r, wr_nxt, rd_r, rd_nxt, wr_p1, wr_p2;
  logic [CW-1:0]     count_r, count_nxt;

  function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_p1 = ptr_inc(wr_r);
  assign wr_p2 = ptr_inc(wr_p1);

  // room for a held byte plus a closing result
  assign room        = count_r <= CW'(DEPTH - 2);
  assign head.nempty = count_r != '0;
  assign head.res    = mem_r[rd_r];

  always_comb begin
    case (push.cnt)
      2'd1:    wr_nxt = wr_p1;
      2'd2:    wr_nxt = wr_p2;
      default: wr_nxt = wr_r;
    endcase
    rd_nxt    = pop ? ptr_inc(rd_r) : rd_r;
    count_nxt = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_r]  <= push.e0;
    if (push.cnt == 2'd2) mem_r[wr_p1] <= push.e1;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> room)
    else $error("push without room");

  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd3)
    else $error("more than two results in one cycle");
`endif

endmodule

FILE: src/ccs_back.sv
// Back end: output register that drains the queue onto the result channel.
module ccs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ccs_pkg::ccs_qhead_t head,
  output logic                pop,
  ccs_out_if.source           out_ch
);

  logic              vld_r, vld_nxt;
  ccs_pkg::ccs_res_t res_r;

  assign pop     = head.nempty && (!vld_r || out_ch.ready);
  assign vld_nxt = pop || (vld_r && !out_ch.ready);

  assign out_ch.valid     = vld_r;
  assign out_ch.out_byte  = res_r.data;
  assign out_ch.out_valid = res_r.kept;
  assign out_ch.out_end   = res_r.fin;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= head.res;
  end

endmodule

FILE: src/c_comment_stripper.sv
// Top level of the comment stripper: front end, result queue, output stage.
//
//  channel  | dir | handshake          | payload
//  in_ch    | in  | valid/ready        | in_byte[7:0], in_last
//  out_ch   | out | valid/ready        | out_byte[7:0], out_valid, out_end
//
// One byte accepted per cycle while in_ch.ready is high; each byte's decision
// waits for the next byte (lookahead), then the result passes the queue and the
// output register. A final byte can push two results at once; the queue drains
// one a cycle unless out_ch stalls; in_ch.ready drops while fewer than two queue slots are free.
// rst_n is synchronous and clears the flags, the held-byte marker and the queue.
// Output stalls back up through the queue only; input stalls cost nothing.
module c_comment_stripper #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  ccs_in_if.sink    in_ch,
  ccs_out_if.source out_ch
);

  ccs_pkg::ccs_push_t  push;
  ccs_pkg::ccs_qhead_t head;
  logic                room;
  logic                pop;

  ccs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_room (room),
    .push   (push)
  );

  ccs_queue #(.DEPTH(DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .room  (room),
    .head  (head)
  );

  ccs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

FILE: tb/ccs_checker.sv
// Checker for the comment stripper: mirrors the stripping rules and scores every result.
module ccs_checker (
  input  logic clk,
  input  logic rst_n,
  ccs_in_if    in_mon,
  ccs_out_if   out_mon,
  output int   n_fail,
  output int   n_pending,
  output int   n_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       kept;
    logic       fin;
  } strip_res_t;

  strip_res_t  stripped_q[$];

  // mirror of the block's lookahead and comment tracking
  logic [7:0]  held_ch;
  bit          held_ok;
  logic [7:0]  prior_ch;
  bit          str_f;
  bit          line_f;
  bit          blk_f;

  initial begin
    n_fail    = 0;
    n_checked = 0;
    n_pending = 0;
  end

  function automatic void clear_state();
    held_ch  = ccs_pkg::CH_NUL;
    held_ok  = 1'b0;
    prior_ch = ccs_pkg::CH_NUL;
    str_f    = 1'b0;
    line_f   = 1'b0;
    blk_f    = 1'b0;
  endfunction

  // Updates the flags for one byte and says whether it survives.
  function automatic bit keep_byte(input logic [7:0] c, input bit slash_next,
                                   input bit star_next);
    bit closes;
    closes = 1'b0;
    if (c == ccs_pkg::CH_QUOTE) begin
      if (!line_f && !blk_f) str_f = !str_f;
    end else if (c == ccs_pkg::CH_SLASH && slash_next && !blk_f) begin
      if (!str_f) line_f = 1'b1;
    end else if (c == ccs_pkg::CH_LF || c == ccs_pkg::CH_CR) begin
      line_f = 1'b0;
    end else if (c == ccs_pkg::CH_SLASH && star_next && !line_f) begin
      if (!str_f) blk_f = 1'b1;
    end else if (!str_f && c == ccs_pkg::CH_SLASH && prior_ch == ccs_pkg::CH_STAR) begin
      // closing slash, also a stray one: dropped, and forgets the star
      blk_f  = 1'b0;
      closes = 1'b1;
    end
    prior_ch = closes ? ccs_pkg::CH_NUL : c;
    return !closes && !line_f && !blk_f;
  endfunction

  task automatic strip_step(input logic [7:0] c, input logic fin);
    strip_res_t r;
    strip_res_t h;
    if (held_ok) begin
      if (keep_byte(held_ch, c == ccs_pkg::CH_SLASH, c == ccs_pkg::CH_STAR)) begin
        h.data = held_ch;
        h.kept = 1'b1;
        h.fin  = 1'b0;
        stripped_q.insert(stripped_q.size(), h);
      end
    end
    if (fin) begin
      // final byte has nothing ahead of it
      r.kept = keep_byte(c, 1'b0, 1'b0);
      r.data = r.kept ? c : ccs_pkg::CH_NUL;
      r.fin  = 1'b1;
      stripped_q.insert(stripped_q.size(), r);
      clear_state();
    end else begin
      held_ch = c;
      held_ok = 1'b1;
    end
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    strip_res_t got;
    strip_res_t want;
    if (!rst_n) begin
      clear_state();
      stripped_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{data: out_mon.out_byte, kept: out_mon.out_valid, fin: out_mon.out_end};
        if (stripped_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte %02h valid %b end %b",
                   $time, got.data, got.kept, got.fin);
          n_fail++;
        end else begin
          want = stripped_q.pop_front();
          cmp_field("out_byte", want.data, got.data);
          cmp_field("out_valid", 8'(want.kept), 8'(got.kept));
          cmp_field("out_end", 8'(want.fin), 8'(got.fin));
          n_checked++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        strip_step(in_mon.in_byte, in_mon.in_last);
    end
    n_pending <= stripped_q.size();
  end

endmodule

FILE: tb/tb_top.sv
// Top of the comment stripper testbench: clock, reset, byte stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT          = 400000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_BYTES    = 350;

  typedef enum int {
    TK_PLAIN, TK_STRING, TK_LINE, TK_BLOCK, TK_NOISE, TK_SPECIAL, TK_STRAY
  } tok_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  ccs_in_if  in_ch();
  ccs_out_if out_ch();

  int n_fail;
  int n_pending;
  int n_checked;

  int in_idle_pct;
  int out_idle_pct;
  int hold_reqs  = 0;
  int holds_done = 0;
  int cycles     = 0;
  int n_bytes    = 0;
  int n_files    = 0;

  logic [7:0] text_q[$];

  c_comment_stripper u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ccs_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_checked (n_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, n_pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= c;
    in_ch.in_last <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_bytes++;
  endtask

  task automatic send_file();
    for (int i = 0; i < text_q.size(); i++)
      send_item(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    n_files++;
  endtask

  function automatic void add_char(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++)
      add_char(s[i]);
  endfunction

  // Sender goes quiet until every outstanding result has been seen.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  // Mostly ordinary text, with the characters that steer the rules mixed in.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0: return ccs_pkg::CH_SLASH;
      1: return ccs_pkg::CH_STAR;
      2: return ccs_pkg::CH_QUOTE;
      3: return ($urandom_range(1) != 0) ? ccs_pkg::CH_LF : ccs_pkg::CH_CR;
      4: return 8'($urandom_range(255));
      default: return 8'("a") + 8'($urandom_range(25));
    endcase
  endfunction

  function automatic void push_filler();
    int n;
    n = $urandom_range(6);
    repeat (n) add_char(pick_char());
  endfunction

  function automatic void build_file();
    int        n_tok;
    tok_kind_t kind;
    n_tok = $urandom_range(1, 8);
    repeat (n_tok) begin
      kind = tok_kind_t'($urandom_range(9) < 6 ? $urandom_range(TK_STRING, TK_BLOCK)
                                               : $urandom_range(TK_PLAIN, TK_STRAY));
      case (kind)
        TK_PLAIN:   push_str("x = 1;");
        TK_STRING: begin
          add_char(ccs_pkg::CH_QUOTE);
          push_filler();
          add_char(ccs_pkg::CH_QUOTE);
        end
        TK_LINE: begin
          push_str("//");
          push_filler();
          add_char(($urandom_range(1) != 0) ? ccs_pkg::CH_LF : ccs_pkg::CH_CR);
        end
        TK_BLOCK: begin
          push_str("/*");
          push_filler();
          push_str("*/");
        end
        TK_NOISE:   add_char(8'($urandom_range(255)));
        TK_SPECIAL: add_char(pick_char());
        TK_STRAY:   push_str("*/");
        default:    push_str(";");
      endcase
    end
  endfunction

  initial begin
    int target;
    rst_n         = 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.in_last <= 1'b0;
    in_idle_pct   = 11;
    out_idle_pct  = 68;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, lone final slash, each comment kind,
    // comment opener inside a string, stray closer, file ending mid-comment
    text_q = {8'h00, 8'hFF};
    send_file();
    push_str("/");
    send_file();
    push_str("a/*x*/b");
    send_file();
    push_str("//c");
    add_char(ccs_pkg::CH_CR);
    push_str("d");
    send_file();
    push_str("\"/*\"");
    send_file();
    push_str("*/");
    send_file();
    push_str("/*");
    send_file();
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 0) ? 11 : (ph == 1) ? 68 : 0;
      out_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 11 : 0;
      // long receiver stall while bytes keep coming, to back the block up
      if (ph == 0) hold_reqs++;
      target = n_bytes + PHASE_BYTES;
      while (n_bytes < target) begin
        build_file();
        send_file();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Stripped %0d files of %0d bytes in total; %0d results checked.",
             n_files, n_bytes, n_checked);
    $display("Covered strings, line and block comments, stray closers and noise bytes.");
    if (n_fail == 0 && n_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: c_comment_stripper.f
src/ccs_pkg.sv
src/ccs_in_if.sv
src/ccs_out_if.sv
src/ccs_front.sv
src/ccs_queue.sv
src/ccs_back.sv
src/c_comment_stripper.sv
tb/ccs_checker.sv
tb/tb_top.sv
